@@ hdl/rlpe_pkg.sv @@
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types, constants and arithmetic helpers of the RGB LED pixel encoder.
// ----------------------------------------------------------------------------
package rlpe_pkg;

  localparam int unsigned ColorW     = 16;
  localparam int unsigned BrightW    = 10;
  localparam int unsigned TickW      = 10;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ProdW      = 2 * ByteW;
  localparam int unsigned WordBits   = 3 * ByteW;
  localparam int unsigned CntW       = $clog2(WordBits + 1);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned RlpeQueueDepth = 2;

  localparam logic [TickW-1:0] ShortTicksRst     = TickW'(3);
  localparam logic [TickW-1:0] LongTicksRst      = TickW'(9);
  localparam logic [TickW-1:0] ResetHalfTicksRst = TickW'(250);

  localparam logic [ProdW-1:0] RoundBias = ProdW'(127);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHORT_TICKS      = 2'd0,
    CFG_LONG_TICKS       = 2'd1,
    CFG_RESET_HALF_TICKS = 2'd2
  } rlpe_cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_DATA
  } rlpe_state_e;

  typedef struct packed {
    logic                bad;
    logic [WordBits-1:0] word;
  } rlpe_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rlpe_qstat_t;

  typedef struct packed {
    logic [TickW-1:0] short_ticks;
    logic [TickW-1:0] long_ticks;
    logic [TickW-1:0] reset_half_ticks;
  } rlpe_cfg_t;

  function automatic logic [ByteW-1:0] clamp_byte(input logic signed [ColorW-1:0] v);
    logic [ByteW-1:0] r;
    if (v[ColorW-1]) begin
      r = '0;
    end else if (|v[ColorW-2:ByteW]) begin
      r = '1;
    end else begin
      r = v[ByteW-1:0];
    end
    return r;
  endfunction

  // floor((p + 127) / 255) for p <= 255*255, via (y + (y >> 8) + 1) >> 8
  function automatic logic [ByteW-1:0] div255_round(input logic [ProdW-1:0] p);
    logic [ProdW-1:0] y;
    logic [ProdW:0]   s;
    y = p + RoundBias;
    s = {1'b0, y} + {{(ByteW + 1){1'b0}}, y[ProdW-1:ByteW]} + (ProdW + 1)'(1);
    return s[ProdW-1:ByteW];
  endfunction

endpackage

@@ hdl/rlpe_ifs.sv @@
// ----------------------------------------------------------------------------
// rlpe_ifs
// Valid/ready channel interfaces: pixel request, pulse symbol, config write.
// ----------------------------------------------------------------------------
interface rlpe_pix_if
  import rlpe_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [ColorW-1:0]  red_in;
  logic signed [ColorW-1:0]  green_in;
  logic signed [ColorW-1:0]  blue_in;
  logic signed [BrightW-1:0] brightness_in;

  modport source (output valid, red_in, green_in, blue_in, brightness_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, brightness_in, output ready);
endinterface

interface rlpe_sym_if
  import rlpe_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             first_level;
  logic [TickW-1:0] first_ticks;
  logic [TickW-1:0] second_ticks;
  logic             last_symbol;
  logic             bad_brightness;

  modport source (output valid, first_level, first_ticks, second_ticks, last_symbol,
                  bad_brightness, input ready);
  modport sink   (input valid, first_level, first_ticks, second_ticks, last_symbol,
                  bad_brightness, output ready);
endinterface

interface rlpe_cfg_if
  import rlpe_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TickW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/rlpe_front.sv @@
// ----------------------------------------------------------------------------
// rlpe_front
// Accepts pixel requests, clamps and scales the colors, packs the GRB word.
// ----------------------------------------------------------------------------
module rlpe_front
  import rlpe_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [ColorW-1:0]  red_i,
  input  logic signed [ColorW-1:0]  green_i,
  input  logic signed [ColorW-1:0]  blue_i,
  input  logic signed [BrightW-1:0] bright_i,
  input  rlpe_qstat_t               qstat_i,
  output logic                      push_o,
  output rlpe_entry_t               entry_o
);

  logic             vld_q, vld_d;
  logic             bad_q, bad_d;
  logic [ProdW-1:0] r_prod_q, r_prod_d;
  logic [ProdW-1:0] g_prod_q, g_prod_d;
  logic [ProdW-1:0] b_prod_q, b_prod_d;
  logic [ByteW-1:0] bright_byte;
  logic             advance;

  assign advance     = !vld_q || !qstat_i.full;
  assign in_ready_o  = advance;
  assign push_o      = vld_q && !qstat_i.full;
  assign bright_byte = bright_i[ByteW-1:0];

  always_comb begin
    vld_d    = advance ? in_valid_i : vld_q;
    bad_d    = bright_i[BrightW-1] || (|bright_i[BrightW-2:ByteW]);
    r_prod_d = clamp_byte(red_i) * bright_byte;
    g_prod_d = clamp_byte(green_i) * bright_byte;
    b_prod_d = clamp_byte(blue_i) * bright_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      bad_q    <= bad_d;
      r_prod_q <= r_prod_d;
      g_prod_q <= g_prod_d;
      b_prod_q <= b_prod_d;
    end
  end

  always_comb begin
    entry_o.bad  = bad_q;
    entry_o.word = {div255_round(g_prod_q), div255_round(r_prod_q), div255_round(b_prod_q)};
  end

endmodule

@@ hdl/rlpe_queue.sv @@
// ----------------------------------------------------------------------------
// rlpe_queue
// Short FIFO of encoded pixel requests between front and back.
// ----------------------------------------------------------------------------
module rlpe_queue
  import rlpe_pkg::*;
#(
  parameter int unsigned Depth = RlpeQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  rlpe_entry_t entry_i,
  input  logic        pop_i,
  output rlpe_entry_t entry_o,
  output rlpe_qstat_t qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0]  LastPtr = PtrW'(Depth - 1);
  localparam logic [CntQW-1:0] FullCnt = CntQW'(Depth);

  rlpe_entry_t      mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntQW-1:0] cnt_q, cnt_d;

  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.full  = (cnt_q == FullCnt);
  assign entry_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntQW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntQW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

@@ hdl/rlpe_back.sv @@
// ----------------------------------------------------------------------------
// rlpe_back
// Serializes one GRB word into 24 pulse symbols and a latch reset symbol, or a bad entry into one error symbol.
// ----------------------------------------------------------------------------
module rlpe_back
  import rlpe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rlpe_cfg_t        cfg_i,
  input  rlpe_qstat_t      qstat_i,
  input  rlpe_entry_t      entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             first_level_o,
  output logic [TickW-1:0] first_ticks_o,
  output logic [TickW-1:0] second_ticks_o,
  output logic             last_symbol_o,
  output logic             bad_brightness_o
);

  localparam logic [CntW-1:0] LastCnt = CntW'(WordBits);

  rlpe_state_e         state_q, state_d;
  logic [WordBits-1:0] shift_q, shift_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                ov_q, ov_d;
  logic                lvl_q, lvl_d;
  logic [TickW-1:0]    t0_q, t0_d;
  logic [TickW-1:0]    t1_q, t1_d;
  logic                last_q, last_d;
  logic                bad_q, bad_d;
  logic                load_ok;
  logic                bit_val;

  assign load_ok = !ov_q || out_ready_i;
  assign pop_o   = load_ok && (state_q == ST_IDLE) && !qstat_i.empty;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o && !entry_i.bad) begin
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (load_ok && (cnt_q == LastCnt)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    shift_d = shift_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q;
    lvl_d   = lvl_q;
    t0_d    = t0_q;
    t1_d    = t1_q;
    last_d  = last_q;
    bad_d   = bad_q;
    bit_val = 1'b0;
    if (load_ok) begin
      ov_d = 1'b0;
      unique case (state_q)
        ST_DATA: begin
          ov_d = 1'b1;
          if (cnt_q == LastCnt) begin
            lvl_d  = 1'b0;
            t0_d   = cfg_i.reset_half_ticks;
            t1_d   = cfg_i.reset_half_ticks;
            last_d = 1'b1;
            bad_d  = 1'b0;
            cnt_d  = '0;
          end else begin
            bit_val = shift_q[WordBits-1];
            shift_d = {shift_q[WordBits-2:0], 1'b0};
            cnt_d   = cnt_q + CntW'(1);
            lvl_d   = 1'b1;
            t0_d    = bit_val ? cfg_i.long_ticks : cfg_i.short_ticks;
            t1_d    = bit_val ? cfg_i.short_ticks : cfg_i.long_ticks;
            last_d  = 1'b0;
            bad_d   = 1'b0;
          end
        end
        ST_IDLE: begin
          if (!qstat_i.empty) begin
            ov_d = 1'b1;
            if (entry_i.bad) begin
              lvl_d  = 1'b0;
              t0_d   = '0;
              t1_d   = '0;
              last_d = 1'b1;
              bad_d  = 1'b1;
            end else begin
              bit_val = entry_i.word[WordBits-1];
              shift_d = {entry_i.word[WordBits-2:0], 1'b0};
              cnt_d   = CntW'(1);
              lvl_d   = 1'b1;
              t0_d    = bit_val ? cfg_i.long_ticks : cfg_i.short_ticks;
              t1_d    = bit_val ? cfg_i.short_ticks : cfg_i.long_ticks;
              last_d  = 1'b0;
              bad_d   = 1'b0;
            end
          end
        end
        default: ov_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    lvl_q   <= lvl_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    last_q  <= last_d;
    bad_q   <= bad_d;
  end

  assign out_valid_o      = ov_q;
  assign first_level_o    = lvl_q;
  assign first_ticks_o    = t0_q;
  assign second_ticks_o   = t1_q;
  assign last_symbol_o    = last_q;
  assign bad_brightness_o = bad_q;

endmodule

@@ hdl/rgb_led_pixel_encoder_top.sv @@
// ----------------------------------------------------------------------------
// rgb_led_pixel_encoder_top
// Pixel requests in, NRZ pulse symbols out, with a config write port.
// A pixel request passes the front register, the queue and the back output register
// before its first symbol is valid. The back end emits 25 symbols per valid pixel and
// one per bad-brightness request, one symbol per cycle from its output register while sym_o.ready is high.
// Reset: control state clears, timing registers return to 3, 9 and 250 ticks.
// ----------------------------------------------------------------------------
module rgb_led_pixel_encoder_top
  import rlpe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = RlpeQueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rlpe_pix_if.sink   pix_i,
  rlpe_sym_if.source sym_o,
  rlpe_cfg_if.sink   cfg_i
);

  rlpe_cfg_t   cfg_q, cfg_d;
  rlpe_qstat_t qstat;
  rlpe_entry_t push_entry;
  rlpe_entry_t head_entry;
  logic        push;
  logic        pop;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SHORT_TICKS:      cfg_d.short_ticks      = cfg_i.data;
        CFG_LONG_TICKS:       cfg_d.long_ticks       = cfg_i.data;
        CFG_RESET_HALF_TICKS: cfg_d.reset_half_ticks = cfg_i.data;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_ticks      <= ShortTicksRst;
      cfg_q.long_ticks       <= LongTicksRst;
      cfg_q.reset_half_ticks <= ResetHalfTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rlpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .red_i      (pix_i.red_in),
    .green_i    (pix_i.green_in),
    .blue_i     (pix_i.blue_in),
    .bright_i   (pix_i.brightness_in),
    .qstat_i    (qstat),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  rlpe_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .qstat_o (qstat)
  );

  rlpe_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .qstat_i          (qstat),
    .entry_i          (head_entry),
    .pop_o            (pop),
    .out_valid_o      (sym_o.valid),
    .out_ready_i      (sym_o.ready),
    .first_level_o    (sym_o.first_level),
    .first_ticks_o    (sym_o.first_ticks),
    .second_ticks_o   (sym_o.second_ticks),
    .last_symbol_o    (sym_o.last_symbol),
    .bad_brightness_o (sym_o.bad_brightness)
  );

  a_bad_pop_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && head_entry.bad |=> sym_o.valid && sym_o.bad_brightness && sym_o.last_symbol)
    else $error("bad-brightness request not reported");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty && (!sym_o.valid || sym_o.ready))
    else $error("queue popped without room at output");

  a_data_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_o.valid && sym_o.first_level |-> !sym_o.last_symbol && !sym_o.bad_brightness)
    else $error("data symbol flagged as last");

endmodule

@@ verif/tb_rgb_led_pixel_encoder_top.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_led_pixel_encoder_top
// Self-checking bench for the RGB LED pixel encoder. Drives pixel requests
// and timing register writes, predicts the 24 data symbols and the latch
// symbol of each pixel (or the single error symbol), and compares every
// accepted symbol in order. Corner requests run first, then random requests
// in four phases, the first unthrottled, with different timing register settings.
// ----------------------------------------------------------------------------
module tb_rgb_led_pixel_encoder_top;
  import rlpe_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned RandPerPhase = 25;
  localparam int unsigned MaxPrints    = 100;

  localparam logic [CfgIdxW-1:0] CfgIdxUnmapped = 2'd3;

  typedef struct packed {
    logic [ColorW-1:0]  red;
    logic [ColorW-1:0]  green;
    logic [ColorW-1:0]  blue;
    logic [BrightW-1:0] bright;
  } pixel_req_t;

  typedef struct packed {
    logic             first_level;
    logic [TickW-1:0] first_ticks;
    logic [TickW-1:0] second_ticks;
    logic             last_symbol;
    logic             bad_brightness;
  } pulse_sym_t;

  class nrz_pulse_model;
    logic [TickW-1:0] short_ticks;
    logic [TickW-1:0] long_ticks;
    logic [TickW-1:0] reset_half_ticks;
    pulse_sym_t       pending_pulses[$];
    int unsigned      mismatches;

    function new();
      short_ticks      = ShortTicksRst;
      long_ticks       = LongTicksRst;
      reset_half_ticks = ResetHalfTicksRst;
      mismatches       = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] value);
      case (idx)
        CFG_SHORT_TICKS:      short_ticks = value;
        CFG_LONG_TICKS:       long_ticks = value;
        CFG_RESET_HALF_TICKS: reset_half_ticks = value;
        default: ;
      endcase
    endfunction

    function logic [ByteW-1:0] clamp_color(logic [ColorW-1:0] v);
      if ($signed(v) < 0) return '0;
      if ($signed(v) > 255) return '1;
      return v[ByteW-1:0];
    endfunction

    function logic [ByteW-1:0] scale_color(logic [ByteW-1:0] c, logic [ByteW-1:0] b);
      int unsigned prod;
      prod = c;
      prod = prod * b + 127;
      return ByteW'(prod / 255);
    endfunction

    function void add_pixel(pixel_req_t p);
      logic [WordBits-1:0] word;
      logic [ByteW-1:0]    b;
      pulse_sym_t          s;
      int                  i;
      if ($signed(p.bright) < 0 || $signed(p.bright) > 255) begin
        s = '{first_level: 1'b0, first_ticks: '0, second_ticks: '0,
              last_symbol: 1'b1, bad_brightness: 1'b1};
        pending_pulses.push_back(s);
        return;
      end
      b = p.bright[ByteW-1:0];
      word = {scale_color(clamp_color(p.green), b), scale_color(clamp_color(p.red), b),
              scale_color(clamp_color(p.blue), b)};
      for (i = WordBits - 1; i >= 0; i--) begin
        s.first_level    = 1'b1;
        s.first_ticks    = word[i] ? long_ticks : short_ticks;
        s.second_ticks   = word[i] ? short_ticks : long_ticks;
        s.last_symbol    = 1'b0;
        s.bad_brightness = 1'b0;
        pending_pulses.push_back(s);
      end
      s = '{first_level: 1'b0, first_ticks: reset_half_ticks,
            second_ticks: reset_half_ticks, last_symbol: 1'b1, bad_brightness: 1'b0};
      pending_pulses.push_back(s);
    endfunction

    task report(string msg);
      if (mismatches < MaxPrints) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
      mismatches++;
    endtask

    task check_field(string name, logic [TickW-1:0] got, logic [TickW-1:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0d expected %0d", name, got, want));
      end
    endtask

    task match_symbol(pulse_sym_t got);
      pulse_sym_t want;
      if (pending_pulses.size() == 0) begin
        report("symbol with no pending pixel request");
        return;
      end
      want = pending_pulses.pop_front();
      check_field("first_level", TickW'(got.first_level), TickW'(want.first_level));
      check_field("first_ticks", got.first_ticks, want.first_ticks);
      check_field("second_ticks", got.second_ticks, want.second_ticks);
      check_field("last_symbol", TickW'(got.last_symbol), TickW'(want.last_symbol));
      check_field("bad_brightness", TickW'(got.bad_brightness), TickW'(want.bad_brightness));
    endtask
  endclass

  logic           clk_i;
  logic           rst_ni;
  int unsigned    sender_idle_pct = 0;
  int unsigned    receiver_stall_pct = 0;
  int unsigned    cycle_cnt;
  nrz_pulse_model pulse_model;

  rlpe_pix_if pix_if ();
  rlpe_sym_if sym_if ();
  rlpe_cfg_if cfg_if ();

  rgb_led_pixel_encoder_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .sym_o  (sym_if),
    .cfg_i  (cfg_if)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        pulse_model.write_reg(cfg_if.index, cfg_if.data);
      end
      if (pix_if.valid && pix_if.ready) begin
        pulse_model.add_pixel('{red: pix_if.red_in, green: pix_if.green_in,
                                blue: pix_if.blue_in, bright: pix_if.brightness_in});
      end
      if (sym_if.valid && sym_if.ready) begin
        pulse_model.match_symbol('{first_level: sym_if.first_level,
                                   first_ticks: sym_if.first_ticks,
                                   second_ticks: sym_if.second_ticks,
                                   last_symbol: sym_if.last_symbol,
                                   bad_brightness: sym_if.bad_brightness});
      end
    end
  end

  initial begin
    sym_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      sym_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic pixel_req_t px(int r, int g, int b, int br);
    return '{red: ColorW'(r), green: ColorW'(g), blue: ColorW'(b), bright: BrightW'(br)};
  endfunction

  function automatic int rand_color();
    int unsigned mode;
    mode = $urandom_range(3);
    if (mode == 0) return int'($urandom);
    if (mode == 1) return int'($urandom_range(260)) - 2;
    return int'($urandom_range(255));
  endfunction

  function automatic pixel_req_t rand_pixel();
    int br;
    if ($urandom_range(99) < 80) br = int'($urandom_range(255));
    else br = int'($urandom);
    return px(rand_color(), rand_color(), rand_color(), br);
  endfunction

  task automatic send_pixel(pixel_req_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid         <= 1'b1;
    pix_if.red_in        <= p.red;
    pix_if.green_in      <= p.green;
    pix_if.blue_in       <= p.blue;
    pix_if.brightness_in <= p.bright;
    do begin
      @(posedge clk_i);
    end while (!pix_if.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_if.ready);
    @(negedge clk_i);
  endtask

  task automatic set_timing(logic [TickW-1:0] short_t, logic [TickW-1:0] long_t,
                            logic [TickW-1:0] reset_t);
    write_reg(CFG_SHORT_TICKS, short_t);
    write_reg(CfgIdxUnmapped, TickW'($urandom));
    write_reg(CFG_LONG_TICKS, long_t);
    write_reg(CFG_RESET_HALF_TICKS, reset_t);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pulse_model.pending_pulses.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned count);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_pixel(rand_pixel());
    pix_if.valid <= 1'b0;
    wait_idle();
  endtask

  initial begin
    pulse_model          = new();
    rst_ni               = 1'b0;
    pix_if.valid         = 1'b0;
    pix_if.red_in        = '0;
    pix_if.green_in      = '0;
    pix_if.blue_in       = '0;
    pix_if.brightness_in = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CFG_SHORT_TICKS;
    cfg_if.data          = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_pixel(px(0, 0, 0, 255));
    send_pixel(px(255, 255, 255, 255));
    send_pixel(px(32767, -32768, 256, 255));
    send_pixel(px(-1, 255, 0, 255));
    send_pixel(px('h80, 'h55, 'hAA, 255));
    send_pixel(px(200, 100, 50, 0));
    send_pixel(px(200, 100, 50, 1));
    send_pixel(px(255, 255, 255, 128));
    send_pixel(px(100, 100, 100, 256));
    send_pixel(px(100, 100, 100, -1));
    send_pixel(px(100, 100, 100, -512));
    send_pixel(px(100, 100, 100, 511));
    send_pixel(px(-32768, 32767, -32768, 127));
    send_pixel(px(1, 254, 128, 254));
    send_pixel(px(-21846, 21845, 300, 200));
    pix_if.valid <= 1'b0;
    wait_idle();

    run_phase(0, 0, RandPerPhase);
    set_timing(1, 1023, 1023);
    run_phase(45, 0, RandPerPhase);
    set_timing(0, 0, 0);
    run_phase(0, 45, RandPerPhase);
    set_timing(1023, 1, 1);
    run_phase(27, 27, RandPerPhase);

    if (pulse_model.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
